[rtl/assert_macros.svh]
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, sampled on clk_i, idle while rst_ni is low
`define HSFC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hsfc assertion failed");

// Implication in the following cycle
`define HSFC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hsfc assertion failed");

`endif

[rtl/hsfc_pkg.sv]
// Package: widths, codes, bounds and sideband types of the spring force core
`timescale 1ns / 1ps
package hsfc_pkg;

  localparam int POS_W    = 20;
  localparam int FRAC     = 8;
  localparam int DIFF_W   = POS_W + 1;
  localparam int GAIN_W   = 16;
  localparam int MAX_W    = 20;
  localparam int PROD_W   = GAIN_W + 1 + DIFF_W;
  localparam int MAG_W    = 28;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int SUM_W    = SQ_W + 2;
  localparam int MSQ_W    = 2 * MAX_W;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int REM_W    = ROOT_W + 2;
  localparam int NUM_W    = MAG_W + MAX_W;
  localparam int QUO_W    = MAX_W;
  localparam int DREM_W   = ROOT_W + 1;
  localparam int FORCE_W  = 21;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  localparam logic [MAX_W-1:0]  MAX_FORCE_RST = MAX_W'(655);
  localparam logic [GAIN_W-1:0] GAIN_RST      = GAIN_W'(3277);

  localparam int BOX_X_LO = -60 * (2 ** FRAC);
  localparam int BOX_X_HI =  60 * (2 ** FRAC);
  localparam int BOX_Y_LO = -50 * (2 ** FRAC);
  localparam int BOX_Y_HI =  70 * (2 ** FRAC);
  localparam int BOX_Z_LO = -70 * (2 ** FRAC);
  localparam int BOX_Z_HI =  50 * (2 ** FRAC);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_FORCE   = 1'b0,
    REG_SPRING_GAIN = 1'b1
  } reg_idx_e;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_TARGET = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_FORCE  = 2'd0,
    STAT_ACCEPT = 2'd1,
    STAT_REJECT = 2'd2
  } status_e;

  // Per-transaction control and magnitudes carried beside the arithmetic
  typedef struct packed {
    logic                      vld;
    logic                      tgt;
    status_e                   status;
    logic [2:0]                neg;
    logic [2:0][MAG_W-1:0]     mag;
    logic                      over;
  } side_t;

endpackage

[rtl/hsfc_if.sv]
// Valid/ready channel interfaces for position input and force output
`timescale 1ns / 1ps
interface hsfc_in_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic signed [hsfc_pkg::POS_W-1:0]   coord_x;
  logic signed [hsfc_pkg::POS_W-1:0]   coord_y;
  logic signed [hsfc_pkg::POS_W-1:0]   coord_z;
  modport source (output valid, cmd, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, cmd, coord_x, coord_y, coord_z, output ready);
endinterface

interface hsfc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [hsfc_pkg::FORCE_W-1:0] force_x;
  logic signed [hsfc_pkg::FORCE_W-1:0] force_y;
  logic signed [hsfc_pkg::FORCE_W-1:0] force_z;
  logic [1:0]                          status;
  modport source (output valid, force_x, force_y, force_z, status, input ready);
  modport sink   (input valid, force_x, force_y, force_z, status, output ready);
endinterface

[rtl/hsfc_sqrt_pipe.sv]
// Pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module hsfc_sqrt_pipe (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [hsfc_pkg::SUM_W-1:0]      sum_i,
  output logic [hsfc_pkg::ROOT_W-1:0]     root_o
);

  logic [hsfc_pkg::REM_W-1:0]  rem_q  [hsfc_pkg::ROOT_W];
  logic [hsfc_pkg::ROOT_W-1:0] root_q [hsfc_pkg::ROOT_W];
  logic [hsfc_pkg::SUM_W-1:0]  rad_q  [hsfc_pkg::ROOT_W];

  for (genvar k = 0; k < hsfc_pkg::ROOT_W; k++) begin : g_stage
    logic [hsfc_pkg::REM_W-1:0]  rem_in, rem_try, trial, rem_d;
    logic [hsfc_pkg::ROOT_W-1:0] root_in, root_d;
    logic [hsfc_pkg::SUM_W-1:0]  rad_in, rad_d;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = sum_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    // Bring down the next bit pair and try subtracting 4*root+1
    always_comb begin
      rem_try = {rem_in[hsfc_pkg::REM_W-3:0], rad_in[hsfc_pkg::SUM_W-1 -: 2]};
      trial   = {root_in, 2'b01};
      rad_d   = {rad_in[hsfc_pkg::SUM_W-3:0], 2'b00};
      if (rem_try >= trial) begin
        rem_d  = rem_try - trial;
        root_d = {root_in[hsfc_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_try;
        root_d = {root_in[hsfc_pkg::ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        rad_q[k]  <= rad_d;
      end
    end
  end

  assign root_o = root_q[hsfc_pkg::ROOT_W-1];

endmodule

[rtl/hsfc_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module hsfc_div_pipe (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [hsfc_pkg::NUM_W-1:0]      num_i,
  input  logic [hsfc_pkg::ROOT_W-1:0]     den_i,
  output logic [hsfc_pkg::QUO_W-1:0]      quo_o
);

  logic [hsfc_pkg::DREM_W-1:0] rem_q [hsfc_pkg::QUO_W];
  logic [hsfc_pkg::QUO_W-1:0]  low_q [hsfc_pkg::QUO_W];
  logic [hsfc_pkg::QUO_W-1:0]  quo_q [hsfc_pkg::QUO_W];
  logic [hsfc_pkg::ROOT_W-1:0] den_q [hsfc_pkg::QUO_W];

  for (genvar k = 0; k < hsfc_pkg::QUO_W; k++) begin : g_stage
    logic [hsfc_pkg::DREM_W-1:0] rem_in, rem_try, rem_d;
    logic [hsfc_pkg::QUO_W-1:0]  low_in, quo_in, quo_d;
    logic [hsfc_pkg::ROOT_W-1:0] den_in;

    // The quotient fits QUO_W bits, so the upper numerator bits start as remainder
    if (k == 0) begin : g_first
      assign rem_in = hsfc_pkg::DREM_W'(num_i[hsfc_pkg::NUM_W-1:hsfc_pkg::QUO_W]);
      assign low_in = num_i[hsfc_pkg::QUO_W-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end

    // Shift in one numerator bit and subtract the divisor where it fits
    always_comb begin
      rem_try = {rem_in[hsfc_pkg::DREM_W-2:0], low_in[hsfc_pkg::QUO_W-1]};
      if (rem_try >= {1'b0, den_in}) begin
        rem_d = rem_try - {1'b0, den_in};
        quo_d = {quo_in[hsfc_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem_d = rem_try;
        quo_d = {quo_in[hsfc_pkg::QUO_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        low_q[k] <= {low_in[hsfc_pkg::QUO_W-2:0], 1'b0};
        quo_q[k] <= quo_d;
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[hsfc_pkg::QUO_W-1];

endmodule

[rtl/haptic_spring_force_clamp_core.sv]
// Top level: virtual spring force with target box check and magnitude clamp
// One transaction per clock when not stalled; one result per transaction, in order.
// A result is valid once its transaction has passed all stages: the accepting edge
// loads the first of four stages that form the difference, product, squares and sum,
// then the square root takes one stage per root bit (29) and the three dividers one
// stage per quotient bit (20), and a final register holds the result. A stalled output
// freezes the pipeline only while its last stage holds a transaction, so bubbles still
// drain and input keeps flowing.
// An in-box set-target transaction updates the target at acceptance; later samples see it.
// Configuration writes land in registers; the squared limit is registered from them.
`timescale 1ns / 1ps
module haptic_spring_force_clamp_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [hsfc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [hsfc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  hsfc_in_if.sink                            in_i,
  hsfc_out_if.source                         out_o
);

  localparam int SQ_N = hsfc_pkg::ROOT_W;
  localparam int DV_N = hsfc_pkg::QUO_W;

  logic [hsfc_pkg::MAX_W-1:0]  max_force_q;
  logic [hsfc_pkg::GAIN_W-1:0] gain_q;
  logic [hsfc_pkg::MSQ_W-1:0]  max_sq_q;
  logic signed [hsfc_pkg::POS_W-1:0] tgt_x_q, tgt_y_q, tgt_z_q;

  logic en, out_load, accept, in_box;

  // Stage A: differences
  hsfc_pkg::side_t a_q;
  logic signed [hsfc_pkg::DIFF_W-1:0] a_diff_q [3];
  // Stage B: magnitudes
  hsfc_pkg::side_t b_q;
  // Stage C: squares
  hsfc_pkg::side_t c_q;
  logic [hsfc_pkg::SQ_W-1:0] c_sq_q [3];
  // Stage D: sum, numerators
  hsfc_pkg::side_t d_q;
  logic [hsfc_pkg::SUM_W-1:0] d_sum_q;
  logic [hsfc_pkg::NUM_W-1:0] d_num_q [3];
  // Sideband beside the root and the dividers
  hsfc_pkg::side_t sq_side_q [SQ_N];
  logic [hsfc_pkg::NUM_W-1:0] sq_num_q [SQ_N][3];
  hsfc_pkg::side_t dv_side_q [DV_N];

  logic [hsfc_pkg::ROOT_W-1:0] root;
  logic [hsfc_pkg::QUO_W-1:0]  quo [3];
  hsfc_pkg::side_t last;

  logic signed [hsfc_pkg::FORCE_W-1:0] force_d [3];
  logic signed [hsfc_pkg::FORCE_W-1:0] force_q [3];
  hsfc_pkg::status_e status_q;
  logic out_vld_q;

  // Advance everything unless a finished transaction is blocked at the output
  assign last     = dv_side_q[DV_N-1];
  assign out_load = !out_vld_q || out_o.ready;
  assign en       = out_load || !last.vld;
  assign in_i.ready = en;
  assign accept   = in_i.valid && en;

  // Check the requested target against the fixed box
  assign in_box = (in_i.coord_x >= hsfc_pkg::BOX_X_LO) && (in_i.coord_x <= hsfc_pkg::BOX_X_HI)
               && (in_i.coord_y >= hsfc_pkg::BOX_Y_LO) && (in_i.coord_y <= hsfc_pkg::BOX_Y_HI)
               && (in_i.coord_z >= hsfc_pkg::BOX_Z_LO) && (in_i.coord_z <= hsfc_pkg::BOX_Z_HI);

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_force_q <= hsfc_pkg::MAX_FORCE_RST;
      gain_q      <= hsfc_pkg::GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (hsfc_pkg::reg_idx_e'(cfg_idx_i))
        hsfc_pkg::REG_MAX_FORCE:   max_force_q <= cfg_data_i[hsfc_pkg::MAX_W-1:0];
        hsfc_pkg::REG_SPRING_GAIN: gain_q      <= cfg_data_i[hsfc_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Precompute the squared limit
  always_ff @(posedge clk_i) begin
    max_sq_q <= max_force_q * max_force_q;
  end

  // Store an in-box target at acceptance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_x_q <= '0;
      tgt_y_q <= '0;
      tgt_z_q <= '0;
    end else if (accept && in_i.cmd == hsfc_pkg::CMD_TARGET && in_box) begin
      tgt_x_q <= in_i.coord_x;
      tgt_y_q <= in_i.coord_y;
      tgt_z_q <= in_i.coord_z;
    end
  end

  // Stage A: capture command and differences
  always_ff @(posedge clk_i or negedge rst_ni) begin
    hsfc_pkg::side_t a_d;
    if (!rst_ni) begin
      a_q <= '0;
    end else if (en) begin
      a_d        = '0;
      a_d.vld    = in_i.valid;
      a_d.tgt    = in_i.cmd;
      a_d.status = (in_i.cmd == hsfc_pkg::CMD_SAMPLE) ? hsfc_pkg::STAT_FORCE :
                   in_box ? hsfc_pkg::STAT_ACCEPT : hsfc_pkg::STAT_REJECT;
      a_q <= a_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_diff_q[0] <= hsfc_pkg::DIFF_W'(tgt_x_q) - hsfc_pkg::DIFF_W'(in_i.coord_x);
      a_diff_q[1] <= hsfc_pkg::DIFF_W'(tgt_y_q) - hsfc_pkg::DIFF_W'(in_i.coord_y);
      a_diff_q[2] <= hsfc_pkg::DIFF_W'(tgt_z_q) - hsfc_pkg::DIFF_W'(in_i.coord_z);
    end
  end

  // Stage B: multiply by gain, take magnitude, drop fraction bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic signed [hsfc_pkg::PROD_W-1:0] prod;
    logic [hsfc_pkg::PROD_W-1:0] prod_abs;
    hsfc_pkg::side_t b_d;
    if (!rst_ni) begin
      b_q <= '0;
    end else if (en) begin
      b_d = a_q;
      for (int i = 0; i < 3; i++) begin
        prod = $signed({1'b0, gain_q}) * a_diff_q[i];
        prod_abs = prod[hsfc_pkg::PROD_W-1] ? hsfc_pkg::PROD_W'(-prod) : prod;
        b_d.neg[i] = prod[hsfc_pkg::PROD_W-1];
        b_d.mag[i] = prod_abs[hsfc_pkg::FRAC +: hsfc_pkg::MAG_W];
      end
      b_q <= b_d;
    end
  end

  // Stage C: square each component
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
    end else if (en) begin
      c_q <= b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c_sq_q[i] <= b_q.mag[i] * b_q.mag[i];
      end
    end
  end

  // Stage D: sum squares, compare with limit, form numerators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    hsfc_pkg::side_t d_d;
    if (!rst_ni) begin
      d_q <= '0;
    end else if (en) begin
      d_d      = c_q;
      d_d.over = (hsfc_pkg::SUM_W'(c_sq_q[0]) + hsfc_pkg::SUM_W'(c_sq_q[1])
                  + hsfc_pkg::SUM_W'(c_sq_q[2])) > hsfc_pkg::SUM_W'(max_sq_q);
      d_q <= d_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_sum_q <= hsfc_pkg::SUM_W'(c_sq_q[0]) + hsfc_pkg::SUM_W'(c_sq_q[1])
               + hsfc_pkg::SUM_W'(c_sq_q[2]);
      for (int i = 0; i < 3; i++) begin
        d_num_q[i] <= c_q.mag[i] * max_force_q;
      end
    end
  end

  hsfc_sqrt_pipe u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .sum_i  (d_sum_q),
    .root_o (root)
  );

  // Carry sideband and numerators beside the root
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SQ_N; k++) sq_side_q[k] <= '0;
    end else if (en) begin
      sq_side_q[0] <= d_q;
      for (int k = 1; k < SQ_N; k++) sq_side_q[k] <= sq_side_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_num_q[0] <= d_num_q;
      for (int k = 1; k < SQ_N; k++) sq_num_q[k] <= sq_num_q[k-1];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    hsfc_div_pipe u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (sq_num_q[SQ_N-1][i]),
      .den_i  (root),
      .quo_o  (quo[i])
    );
  end

  // Carry sideband beside the dividers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DV_N; k++) dv_side_q[k] <= '0;
    end else if (en) begin
      dv_side_q[0] <= sq_side_q[SQ_N-1];
      for (int k = 1; k < DV_N; k++) dv_side_q[k] <= dv_side_q[k-1];
    end
  end

  // Pick scaled or raw magnitude, restore sign, zero for target transactions
  always_comb begin
    logic [hsfc_pkg::QUO_W-1:0] m;
    for (int i = 0; i < 3; i++) begin
      m = last.over ? quo[i] : last.mag[i][hsfc_pkg::QUO_W-1:0];
      if (last.tgt) begin
        force_d[i] = '0;
      end else if (last.neg[i]) begin
        force_d[i] = -$signed({1'b0, m});
      end else begin
        force_d[i] = $signed({1'b0, m});
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= last.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      force_q  <= force_d;
      status_q <= last.status;
    end
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.force_x = force_q[0];
  assign out_o.force_y = force_q[1];
  assign out_o.force_z = force_q[2];
  assign out_o.status  = status_q;

endmodule

[rtl/hsfc_checker.sv]
// Port-level checker for the spring force core, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hsfc_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic [hsfc_pkg::FORCE_W-1:0]       force_x_i,
  input logic [hsfc_pkg::FORCE_W-1:0]       force_y_i,
  input logic [hsfc_pkg::FORCE_W-1:0]       force_z_i,
  input logic [1:0]                         status_i
);

  // A stalled result holds
  `HSFC_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(force_x_i) && $stable(status_i))

  // Target transactions carry no force
  `HSFC_ASSERT_IMP(a_tgt_zero, out_valid_i && status_i != hsfc_pkg::STAT_FORCE, force_x_i == '0 && force_y_i == '0 && force_z_i == '0)

  // An output that drains never blocks the input
  `HSFC_ASSERT_IMP(a_ready_flow, out_ready_i, in_ready_i)

endmodule

bind haptic_spring_force_clamp_core hsfc_checker u_hsfc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .force_x_i   (out_o.force_x),
  .force_y_i   (out_o.force_y),
  .force_z_i   (out_o.force_z),
  .status_i    (out_o.status)
);

[test/haptic_spring_force_clamp_checker.sv]
// Checker: watches both channels, predicts the spring force and compares results
`timescale 1ns / 1ps
module haptic_spring_force_clamp_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hsfc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hsfc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  hsfc_in_if                              mon_in,
  hsfc_out_if                             mon_out,
  output int                              err_count_o,
  output int                              pending_o
);

  typedef struct {
    logic signed [hsfc_pkg::FORCE_W-1:0] fx;
    logic signed [hsfc_pkg::FORCE_W-1:0] fy;
    logic signed [hsfc_pkg::FORCE_W-1:0] fz;
    hsfc_pkg::status_e                   status;
  } force_res_t;

  force_res_t                        expected_forces[$];
  logic [hsfc_pkg::MAX_W-1:0]        limit_q;
  logic [hsfc_pkg::GAIN_W-1:0]       gain_q;
  logic signed [hsfc_pkg::POS_W-1:0] tgt_q [3];

  assign pending_o = expected_forces.size();

  // Truncated integer square root, bit by bit
  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Work out the result of one transaction and update the stored target
  function automatic force_res_t spring_force(hsfc_pkg::cmd_e cmd,
                                              logic signed [hsfc_pkg::POS_W-1:0] c [3]);
    force_res_t      res;
    longint          prod;
    longint unsigned mag [3];
    bit              neg [3];
    longint unsigned sum;
    longint unsigned root;
    longint unsigned lim;
    bit              in_box;
    res.fx = '0;
    res.fy = '0;
    res.fz = '0;
    if (cmd == hsfc_pkg::CMD_TARGET) begin
      in_box = (int'(c[0]) >= hsfc_pkg::BOX_X_LO) && (int'(c[0]) <= hsfc_pkg::BOX_X_HI) &&
               (int'(c[1]) >= hsfc_pkg::BOX_Y_LO) && (int'(c[1]) <= hsfc_pkg::BOX_Y_HI) &&
               (int'(c[2]) >= hsfc_pkg::BOX_Z_LO) && (int'(c[2]) <= hsfc_pkg::BOX_Z_HI);
      if (in_box) tgt_q = c;
      res.status = in_box ? hsfc_pkg::STAT_ACCEPT : hsfc_pkg::STAT_REJECT;
      return res;
    end
    // Raw magnitudes stay below 2^28 at these widths, so no pre-shift
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      prod   = longint'(gain_q) * (longint'(tgt_q[i]) - longint'(c[i]));
      neg[i] = prod < 0;
      mag[i] = longint'(neg[i] ? -prod : prod) >> hsfc_pkg::FRAC;
      sum   += mag[i] * mag[i];
    end
    lim = longint'(limit_q);
    if (sum > lim * lim) begin
      root = int_sqrt(sum);
      if (root == 0) root = 1;
      for (int i = 0; i < 3; i++) mag[i] = (mag[i] * lim) / root;
    end
    res.fx     = hsfc_pkg::FORCE_W'(neg[0] ? -mag[0] : mag[0]);
    res.fy     = hsfc_pkg::FORCE_W'(neg[1] ? -mag[1] : mag[1]);
    res.fz     = hsfc_pkg::FORCE_W'(neg[2] ? -mag[2] : mag[2]);
    res.status = hsfc_pkg::STAT_FORCE;
    return res;
  endfunction

  // Track registers, predict on input transactions, compare on output ones
  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [hsfc_pkg::POS_W-1:0] coords [3];
    force_res_t                        exp_r;
    if (!rst_ni) begin
      limit_q      = hsfc_pkg::MAX_FORCE_RST;
      gain_q       = hsfc_pkg::GAIN_RST;
      tgt_q        = '{default: '0};
      err_count_o <= 0;
      expected_forces.delete();
    end else begin
      if (cfg_we_i) begin
        if (hsfc_pkg::reg_idx_e'(cfg_idx_i) == hsfc_pkg::REG_MAX_FORCE) begin
          limit_q = cfg_data_i[hsfc_pkg::MAX_W-1:0];
        end else begin
          gain_q = cfg_data_i[hsfc_pkg::GAIN_W-1:0];
        end
      end
      if (mon_in.valid && mon_in.ready) begin
        coords = '{mon_in.coord_x, mon_in.coord_y, mon_in.coord_z};
        expected_forces.push_back(spring_force(hsfc_pkg::cmd_e'(mon_in.cmd), coords));
      end
      if (mon_out.valid && mon_out.ready) begin
        if (expected_forces.size() == 0) begin
          $display("%0t: unexpected result fx=%0d fy=%0d fz=%0d status=%0d", $time,
                   mon_out.force_x, mon_out.force_y, mon_out.force_z, mon_out.status);
          err_count_o <= err_count_o + 1;
        end else begin
          exp_r = expected_forces.pop_front();
          if (mon_out.force_x !== exp_r.fx || mon_out.force_y !== exp_r.fy ||
              mon_out.force_z !== exp_r.fz || mon_out.status !== exp_r.status) begin
            $display("%0t: mismatch expected fx=%0d fy=%0d fz=%0d status=%0d", $time,
                     exp_r.fx, exp_r.fy, exp_r.fz, exp_r.status);
            $display("%0t:          actual   fx=%0d fy=%0d fz=%0d status=%0d", $time,
                     mon_out.force_x, mon_out.force_y, mon_out.force_z, mon_out.status);
            err_count_o <= err_count_o + 1;
          end
        end
      end
    end
  end
endmodule

[test/haptic_spring_force_clamp_core_tb.sv]
// Testbench top: drives samples, targets and register writes into the spring force core
`timescale 1ns / 1ps
module haptic_spring_force_clamp_core_tb;

  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 600000;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we;
  logic [hsfc_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [hsfc_pkg::CFG_DATA_W-1:0] cfg_data;
  int                              err_count;
  int                              pending;
  int                              cycles;
  int                              send_idle;
  int                              recv_stall;

  hsfc_in_if  in_ch ();
  hsfc_out_if out_ch ();

  haptic_spring_force_clamp_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  haptic_spring_force_clamp_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .mon_in      (in_ch),
    .mon_out     (out_ch),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Stall the receiver at the phase's rate
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  // Guard against a hang
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("haptic_spring_force_clamp_core_tb failed");
      $finish;
    end
  end

  // Offer one transaction, hold it until accepted
  task automatic send_item(hsfc_pkg::cmd_e cmd, int x, int y, int z);
    logic accepted;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= cmd;
    in_ch.coord_x <= hsfc_pkg::POS_W'(x);
    in_ch.coord_y <= hsfc_pkg::POS_W'(y);
    in_ch.coord_z <= hsfc_pkg::POS_W'(z);
    do begin
      @(negedge clk_i);
      accepted = in_ch.ready;
      @(posedge clk_i);
    end while (!accepted);
  endtask

  // Hold the input idle until every expected result has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Drain the pipeline, then write both registers
  task automatic set_config(int limit, int gain);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= hsfc_pkg::REG_MAX_FORCE;
    cfg_data <= hsfc_pkg::CFG_DATA_W'(limit);
    @(posedge clk_i);
    cfg_idx  <= hsfc_pkg::REG_SPRING_GAIN;
    cfg_data <= hsfc_pkg::CFG_DATA_W'(gain);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Coordinate: mostly near the origin at a random scale, sometimes anywhere
  function automatic int rand_coord();
    int span;
    case ($urandom_range(4))
      0: return int'($signed(hsfc_pkg::POS_W'($urandom)));
      1: span = 255;
      2: span = 4095;
      default: span = 20000;
    endcase
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // Random transactions: mostly samples, some targets, pressure pause optional
  task automatic run_random(int n, bit pause_mid);
    for (int k = 0; k < n; k++) begin
      if (pause_mid && k == n / 2) begin
        wait_drained();
      end
      if ($urandom_range(99) < 20) begin
        send_item(hsfc_pkg::CMD_TARGET, rand_coord(), rand_coord(), rand_coord());
      end else begin
        send_item(hsfc_pkg::CMD_SAMPLE, rand_coord(), rand_coord(), rand_coord());
      end
    end
  endtask

  // Stimulus and verdict
  initial begin
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.cmd     = hsfc_pkg::CMD_SAMPLE;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.coord_z = '0;
    out_ch.ready  = 1'b0;
    cycles        = 0;
    send_idle     = 0;
    recv_stall    = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: unit gain so forces equal position offsets
    set_config(655, 256);
    send_item(hsfc_pkg::CMD_SAMPLE, 0, 0, 0);
    send_item(hsfc_pkg::CMD_SAMPLE, -655, -1, 0);
    send_item(hsfc_pkg::CMD_SAMPLE, -1000, 0, 0);
    send_item(hsfc_pkg::CMD_TARGET, hsfc_pkg::BOX_X_LO, hsfc_pkg::BOX_Y_LO,
              hsfc_pkg::BOX_Z_LO);
    send_item(hsfc_pkg::CMD_TARGET, hsfc_pkg::BOX_X_HI, hsfc_pkg::BOX_Y_HI,
              hsfc_pkg::BOX_Z_HI);
    send_item(hsfc_pkg::CMD_TARGET, hsfc_pkg::BOX_X_HI + 1, 0, 0);
    send_item(hsfc_pkg::CMD_TARGET, hsfc_pkg::BOX_X_LO - 1, 0, 0);
    send_item(hsfc_pkg::CMD_TARGET, 0, hsfc_pkg::BOX_Y_LO - 1, 0);
    send_item(hsfc_pkg::CMD_TARGET, 0, hsfc_pkg::BOX_Y_HI + 1, 0);
    send_item(hsfc_pkg::CMD_TARGET, 0, 0, hsfc_pkg::BOX_Z_LO - 1);
    send_item(hsfc_pkg::CMD_TARGET, 0, 0, hsfc_pkg::BOX_Z_HI + 1);
    send_item(hsfc_pkg::CMD_TARGET, -524288, -524288, -524288);
    send_item(hsfc_pkg::CMD_TARGET, 524287, 524287, 524287);
    send_item(hsfc_pkg::CMD_SAMPLE, 524287, 524287, 524287);
    send_item(hsfc_pkg::CMD_SAMPLE, -524288, -524288, -524288);
    send_item(hsfc_pkg::CMD_TARGET, 0, 0, 0);
    send_item(hsfc_pkg::CMD_SAMPLE, 0, 0, -100);
    send_item(hsfc_pkg::CMD_SAMPLE, 524287, -524288, 3);

    // Random phases over register settings and idling modes
    set_config(1048575, 65535);
    run_random(140, 1'b1);
    set_config(0, 65535);
    send_idle = 82;
    run_random(130, 1'b0);
    set_config(50000, 20000);
    send_idle  = 0;
    recv_stall = 82;
    run_random(130, 1'b0);
    set_config(1000, 0);
    send_idle  = 12;
    recv_stall = 12;
    run_random(60, 1'b0);
    set_config($urandom_range(1048575), $urandom_range(65535));
    send_idle  = 0;
    recv_stall = 0;
    run_random(140, 1'b0);
    set_config(655, 3277);
    send_idle  = 12;
    recv_stall = 12;
    run_random(100, 1'b0);

    // Drain and decide
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("haptic_spring_force_clamp_core_tb passed");
    end else begin
      $display("haptic_spring_force_clamp_core_tb failed");
    end
    $finish;
  end
endmodule
